// File: sv/sjf_nonpreemptive_scheduler_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef SJF_NONPREEMPTIVE_SCHEDULER_ASSERT_SVH
`define SJF_NONPREEMPTIVE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SJF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

// Next-cycle implication, disabled during reset.
`define SJF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`endif

// File: sv/sjf_pkg.sv
// Shared constants and types of the shortest-job-first scheduler.
package sjf_pkg;

   localparam int MAX_JOBS  = 16;
   localparam int IDX_W     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W     = $clog2(MAX_JOBS + 1);
   localparam int BURST_W   = 16;
   localparam int ARR_W     = 16;
   localparam int TIME_W    = 21;
   localparam int SUM_W     = 25;
   localparam int JOB_IDX_W = 4;
   localparam int WORD_W    = BURST_W + ARR_W;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [BURST_W-1:0] burst_type;
   typedef logic [ARR_W-1:0]   arr_type;
   typedef logic [TIME_W-1:0]  time_type;
   typedef logic [SUM_W-1:0]   sum_type;
   typedef logic [WORD_W-1:0]  word_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   // One store entry as it comes out of the memory during a scan.
   typedef struct packed {
      logic     vld;
      idx_type  idx;
      logic     pending;
      logic     first;
      time_type now;
   } scan_type;

   // Best candidates found by a scan.
   typedef struct packed {
      logic      found_ready;
      idx_type   rdy_idx;
      burst_type rdy_burst;
      arr_type   rdy_arr;
      logic      found_any;
      idx_type   erl_idx;
      burst_type erl_burst;
      arr_type   erl_arr;
   } pick_type;

endpackage

// File: sv/sjf_job_ram.sv
// Job store: one write port, one registered read port.
module sjf_job_ram (
   input  logic             clock,
   input  logic             wr_en,
   input  sjf_pkg::idx_type wr_addr,
   input  sjf_pkg::word_type wr_data,
   input  sjf_pkg::idx_type rd_addr,
   output sjf_pkg::word_type rd_data
);
   import sjf_pkg::*;

   word_type mem [MAX_JOBS];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sjf_pick.sv
// Scan comparator: tracks the shortest ready job and the earliest pending job.
module sjf_pick (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  sjf_pkg::scan_type scan,
   input  sjf_pkg::burst_type burst,
   input  sjf_pkg::arr_type  arrival,
   output sjf_pkg::pick_type pick
);
   import sjf_pkg::*;

   pick_type pick_ff;
   pick_type pick_in;
   logic     ready;
   logic     take_rdy;
   logic     take_erl;

   always_comb begin
      // On the first selection of a pass only job zero qualifies.
      if (scan.first) begin
         ready = (scan.idx == '0);
      end else begin
         ready = scan.pending && (TIME_W'(arrival) <= scan.now);
      end
      take_rdy = scan.vld && ready &&
                 (!pick_ff.found_ready || (burst < pick_ff.rdy_burst));
      // Earliest arrival, then shortest burst among equal arrivals.
      take_erl = scan.vld && scan.pending &&
                 (!pick_ff.found_any || (arrival < pick_ff.erl_arr) ||
                  ((arrival == pick_ff.erl_arr) && (burst < pick_ff.erl_burst)));

      pick_in = pick_ff;
      if (clear) begin
         pick_in.found_ready = 1'b0;
         pick_in.found_any   = 1'b0;
      end else begin
         if (take_rdy) begin
            pick_in.found_ready = 1'b1;
            pick_in.rdy_idx     = scan.idx;
            pick_in.rdy_burst   = burst;
            pick_in.rdy_arr     = arrival;
         end
         if (take_erl) begin
            pick_in.found_any = 1'b1;
            pick_in.erl_idx   = scan.idx;
            pick_in.erl_burst = burst;
            pick_in.erl_arr   = arrival;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pick_ff <= '0;
      end else begin
         pick_ff <= pick_in;
      end
   end

   assign pick = pick_ff;

endmodule

// File: sv/sjf_nonpreemptive_scheduler.sv
// Non-preemptive shortest-job-first scheduler, top level.
// Loading: one job word per cycle while idle; a last_job word starts the pass.
// Pass: each result comes from a memory scan of all stored jobs, a drain state
// and a decide state; the decide state waits while the result port stalls.
// First result registers after the scan, drain and decide states that follow the last_job word.
// Reset (synchronous) clears state, counters, pending flags; store stays as is.
module sjf_nonpreemptive_scheduler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [sjf_pkg::BURST_W-1:0]    req_burst_time,
   input  logic [sjf_pkg::ARR_W-1:0]      req_arrival_time,
   input  logic                           req_last_job,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sjf_pkg::JOB_IDX_W-1:0]  rsp_job_index,
   output logic [sjf_pkg::TIME_W-1:0]     rsp_start_time,
   output logic [sjf_pkg::TIME_W-1:0]     rsp_wait_time,
   output logic [sjf_pkg::SUM_W-1:0]      rsp_total_wait,
   output logic                           rsp_last_result
);
   import sjf_pkg::*;

   `include "sjf_nonpreemptive_scheduler_assert.svh"

   state_type state_ff, state_in;
   cnt_type   count_ff;
   cnt_type   done_ff;
   idx_type   addr_ff;
   idx_type   rd_idx_ff;
   logic      rd_vld_ff;
   logic      first_ff;
   time_type  time_ff, time_in;
   sum_type   sum_ff, sum_in;
   logic [MAX_JOBS-1:0] pending_ff;

   logic [JOB_IDX_W-1:0] rsp_job_index_ff;
   time_type  rsp_start_time_ff;
   time_type  rsp_wait_time_ff;
   sum_type   rsp_total_wait_ff;
   logic      rsp_last_result_ff;
   logic      rsp_valid_ff;

   logic      req_acc;
   logic      store_ok;
   logic      ram_we;
   logic      issue;
   logic      pick_clear;
   logic      out_free;
   logic      emit;
   logic      is_last;
   logic      scan_end;
   idx_type   sel_idx;
   burst_type sel_burst;
   arr_type   sel_arr;
   time_type  start;
   time_type  wait_val;
   word_type  rd_word;
   scan_type  scan;
   pick_type  pick;

   sjf_job_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({req_burst_time, req_arrival_time}),
      .rd_addr (addr_ff),
      .rd_data (rd_word)
   );

   always_comb begin
      scan.vld     = rd_vld_ff;
      scan.idx     = rd_idx_ff;
      scan.pending = pending_ff[rd_idx_ff];
      scan.first   = first_ff;
      scan.now     = time_ff;
   end

   sjf_pick u_pick (
      .clock   (clock),
      .reset   (reset),
      .clear   (pick_clear),
      .scan    (scan),
      .burst   (rd_word[WORD_W-1:ARR_W]),
      .arrival (rd_word[ARR_W-1:0]),
      .pick    (pick)
   );

   // Control outputs of the sequencer.
   always_comb begin
      req_stall  = (state_ff != ST_LOAD);
      req_acc    = req_valid && !req_stall;
      store_ok   = (count_ff < CNT_W'(MAX_JOBS));
      ram_we     = req_acc && store_ok;
      issue      = (state_ff == ST_SCAN);
      pick_clear = issue && (addr_ff == '0);
      scan_end   = (CNT_W'(addr_ff) == CNT_W'(count_ff - 1'b1));
      out_free   = !rsp_valid_ff || !rsp_stall;
      emit       = (state_ff == ST_DECIDE) && out_free;
      is_last    = (done_ff == CNT_W'(count_ff - 1'b1));

      // With nothing ready, jump the clock to the earliest pending arrival.
      if (pick.found_ready) begin
         sel_idx   = pick.rdy_idx;
         sel_burst = pick.rdy_burst;
         sel_arr   = pick.rdy_arr;
         start     = time_ff;
      end else begin
         sel_idx   = pick.erl_idx;
         sel_burst = pick.erl_burst;
         sel_arr   = pick.erl_arr;
         start     = TIME_W'(pick.erl_arr);
      end
      if (start >= TIME_W'(sel_arr)) begin
         wait_val = TIME_W'(start - TIME_W'(sel_arr));
      end else begin
         wait_val = '0;
      end
      time_in = TIME_W'(start + TIME_W'(sel_burst));
      sum_in  = SUM_W'(sum_ff + SUM_W'(wait_val));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_acc && req_last_job) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (emit) begin
               state_in = is_last ? ST_LOAD : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         done_ff      <= '0;
         addr_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         first_ff     <= 1'b1;
         time_ff      <= '0;
         sum_ff       <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= issue;
         if (issue && !scan_end) begin
            addr_ff <= addr_ff + 1'b1;
         end else begin
            addr_ff <= '0;
         end
         if (ram_we) begin
            count_ff                        <= count_ff + 1'b1;
            pending_ff[count_ff[IDX_W-1:0]] <= 1'b1;
         end
         if (out_free) begin
            rsp_valid_ff <= emit;
         end
         if (emit) begin
            if (is_last) begin
               // Close the set: drop all bookkeeping for the next one.
               count_ff   <= '0;
               done_ff    <= '0;
               first_ff   <= 1'b1;
               time_ff    <= '0;
               sum_ff     <= '0;
               pending_ff <= '0;
            end else begin
               done_ff             <= done_ff + 1'b1;
               first_ff            <= 1'b0;
               time_ff             <= time_in;
               sum_ff              <= sum_in;
               pending_ff[sel_idx] <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff;
      if (emit) begin
         rsp_job_index_ff   <= JOB_IDX_W'(sel_idx);
         rsp_start_time_ff  <= start;
         rsp_wait_time_ff   <= wait_val;
         rsp_total_wait_ff  <= is_last ? sum_in : '0;
         rsp_last_result_ff <= is_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_job_index   = rsp_job_index_ff;
   assign rsp_start_time  = rsp_start_time_ff;
   assign rsp_wait_time   = rsp_wait_time_ff;
   assign rsp_total_wait  = rsp_total_wait_ff;
   assign rsp_last_result = rsp_last_result_ff;

   `SJF_ASSERT_NOW(a_decide_has_job, clock, reset, state_ff == ST_DECIDE, pick.found_any)
   `SJF_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_JOBS))
   `SJF_ASSERT_NOW(a_done_below_count, clock, reset, state_ff != ST_LOAD, done_ff < count_ff)
   `SJF_ASSERT_NXT(a_pass_closes, clock, reset, emit && is_last,
                   (state_ff == ST_LOAD) && (count_ff == '0) && (pending_ff == '0))

endmodule
